### hw/rtl/ppi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the pose integrator.
package ppi_pkg;

    typedef logic signed [15:0] speed_t;
    typedef logic [23:0]        step_t;
    typedef logic signed [31:0] pos_t;
    typedef logic [31:0]        angle_t;

    // Serial multiplier: a 40-bit multiplicand times a 32-bit multiplier, one nibble per cycle
    localparam int DIGIT_W    = 4;
    localparam int MCAND_W    = 40;
    localparam int MPLIER_W   = 32;
    localparam int ACC_W      = MCAND_W + MPLIER_W;
    localparam int PP_W       = MCAND_W + DIGIT_W;
    localparam int NUM_DIGITS = MPLIER_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // Product scaling back to a binary angle and to Q16.16 metres
    localparam int YAW_SHIFT = 32;
    localparam int POS_SHIFT = 46;
    localparam int DMAG_W    = ACC_W - POS_SHIFT + 1;

    // CORDIC datapath
    localparam int CORD_W     = 33;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 30;

    localparam step_t              TIME_STEP_RST  = 24'd16777;
    localparam logic [31:0]        INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic signed [32:0] CORDIC_X0      = 33'sd652032874;
    localparam pos_t               POS_MAX        = 32'sh7FFF_FFFF;
    localparam pos_t               POS_MIN        = 32'sh8000_0000;

    // atan(2^-i) as a binary angle, full circle = 2^32
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10679838;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41721;
            5'd15:   val = 30'd20860;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2607;
            5'd19:   val = 30'd1303;
            5'd20:   val = 30'd651;
            5'd21:   val = 30'd325;
            5'd22:   val = 30'd162;
            5'd23:   val = 30'd81;
            5'd24:   val = 30'd40;
            5'd25:   val = 30'd20;
            5'd26:   val = 30'd10;
            5'd27:   val = 30'd5;
            5'd28:   val = 30'd2;
            5'd29:   val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

### hw/rtl/ppi_if.sv
// Valid/ready channel interfaces for tick input and pose output.
interface ppi_in_if;
    logic            valid;
    logic            ready;
    ppi_pkg::speed_t forward_speed;
    ppi_pkg::speed_t yaw_rate;

    modport source (output valid, output forward_speed, output yaw_rate, input ready);
    modport sink   (input valid, input forward_speed, input yaw_rate, output ready);
endinterface

interface ppi_out_if;
    logic            valid;
    logic            ready;
    ppi_pkg::pos_t   pos_x;
    ppi_pkg::pos_t   pos_y;
    ppi_pkg::angle_t heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

### hw/rtl/planar_pose_integrator_unit.sv
// Planar dead-reckoning pose integrator: nibble-serial multiplier and iterative CORDIC.
// Ticks are handled one at a time: in_ch.ready is high only while idle, so a new tick is
//   accepted only after the previous pose is written to the output register. Each tick
//   runs five products through the shared nibble-serial multiplier and one CORDIC
//   iteration per cycle.
// A finished pose waits in the output register while the next tick is taken.
// Reset (rst_n low, asynchronous): pose at origin facing +x, time step 16777, no output.
module planar_pose_integrator_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  ppi_pkg::step_t  cfg_wr_data,
    ppi_in_if.sink          in_ch,
    ppi_out_if.source       out_ch
);
    import ppi_pkg::*;

    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
    localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_YAW1  = 4'd1;
    localparam logic [3:0] S_YAW2  = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_CINIT = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_VTS   = 4'd6;
    localparam logic [3:0] S_POSX  = 4'd7;
    localparam logic [3:0] S_POSY  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // Control state
    logic [3:0]           state_reg, state_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    step_t                ts_reg, ts_next;
    pos_t                 pos_x_reg, pos_x_next;
    pos_t                 pos_y_reg, pos_y_next;
    angle_t               yaw_reg, yaw_next;
    logic                 out_valid_reg, out_valid_next;

    // Datapath
    logic [MCAND_W-1:0]       mcand_reg, mcand_next;
    logic [MPLIER_W-1:0]      mplier_reg, mplier_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic signed [CORD_W-1:0] x_reg, x_next;
    logic signed [CORD_W-1:0] y_reg, y_next;
    logic signed [CORD_W-1:0] z_reg, z_next;
    logic                     flip_reg, flip_next;
    logic [MPLIER_W-1:0]      cmag_reg, cmag_next;
    logic [MPLIER_W-1:0]      smag_reg, smag_next;
    logic                     xneg_reg, xneg_next;
    logic                     yneg_reg, yneg_next;
    logic                     v_neg_reg, v_neg_next;
    logic                     w_neg_reg, w_neg_next;
    logic [15:0]              vmag_reg, vmag_next;
    logic [15:0]              wmag_reg, wmag_next;
    pos_t                     out_x_reg, out_x_next;
    pos_t                     out_y_reg, out_y_next;
    angle_t                   out_hd_reg, out_hd_next;

    // Combinational helpers
    logic                     mult_state, mult_load, mult_last;
    logic [PP_W-1:0]          pp;
    logic [PP_W-1:0]          hi_sum;
    logic [ACC_W-1:0]         acc_step;
    logic [15:0]              vmag_in, wmag_in;
    logic [31:0]              yaw_dmag;
    logic signed [CORD_W-1:0] x_sh, y_sh, atan_z;
    logic [CORD_W-1:0]        x_abs, y_abs;
    logic                     flip_in;
    logic [31:0]              res_ang;
    pos_t                     pos_base;
    logic                     pos_neg;
    logic [DMAG_W-1:0]        pos_dmag;
    logic [32:0]              pos_delta, pos_sum;
    pos_t                     pos_sat;
    logic                     slot_free;

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.pos_x   = out_x_reg;
    assign out_ch.pos_y   = out_y_reg;
    assign out_ch.heading = out_hd_reg;

    // Magnitudes of the incoming speeds
    assign vmag_in = in_ch.forward_speed[15] ? (~in_ch.forward_speed + 16'd1)
                                             : in_ch.forward_speed;
    assign wmag_in = in_ch.yaw_rate[15] ? (~in_ch.yaw_rate + 16'd1) : in_ch.yaw_rate;

    // One nibble of the multiplier per cycle into a right-shifting accumulator
    assign mult_state = (state_reg == S_YAW1) || (state_reg == S_YAW2) ||
                        (state_reg == S_VTS)  || (state_reg == S_POSX) ||
                        (state_reg == S_POSY);
    assign mult_load  = mult_state && (dig_cnt_reg == '0);
    assign mult_last  = (dig_cnt_reg == LAST_DIGIT);
    assign pp         = PP_W'(mcand_reg) * PP_W'(mplier_reg[DIGIT_W-1:0]);
    assign hi_sum     = PP_W'(acc_reg[ACC_W-1:MPLIER_W]) + pp;
    assign acc_step   = {hi_sum, acc_reg[MPLIER_W-1:DIGIT_W]};

    // Heading step magnitude, rounded at the binary point
    assign yaw_dmag = acc_reg[YAW_SHIFT+31:YAW_SHIFT] + {31'b0, acc_reg[YAW_SHIFT-1]};

    // CORDIC micro-rotation operands
    assign x_sh   = x_reg >>> iter_reg;
    assign y_sh   = y_reg >>> iter_reg;
    assign atan_z = CORD_W'(atan_lut(ATAN_IDX_W'(iter_reg)));
    assign x_abs  = x_reg[CORD_W-1] ? CORD_W'(-x_reg) : CORD_W'(x_reg);
    assign y_abs  = y_reg[CORD_W-1] ? CORD_W'(-y_reg) : CORD_W'(y_reg);

    // Fold the left half-plane onto the right one
    assign flip_in = yaw_reg[31] ^ yaw_reg[30];
    assign res_ang = {yaw_reg[31] ^ flip_in, yaw_reg[30:0]};

    // Shared rounding and saturating add for the x and y updates
    assign pos_base  = (state_reg == S_FIN) ? pos_y_reg : pos_x_reg;
    assign pos_neg   = (state_reg == S_FIN) ? yneg_reg : xneg_reg;
    assign pos_dmag  = DMAG_W'(acc_reg[ACC_W-1:POS_SHIFT]) + DMAG_W'(acc_reg[POS_SHIFT-1]);
    assign pos_delta = pos_neg ? (33'd0 - 33'(pos_dmag)) : 33'(pos_dmag);
    assign pos_sum   = {pos_base[31], pos_base} + pos_delta;

    always_comb
    begin
        unique case (pos_sum[32:31])
            2'b01:   pos_sat = POS_MAX;
            2'b10:   pos_sat = POS_MIN;
            default: pos_sat = pos_sum[31:0];
        endcase
    end

    assign slot_free = !out_valid_reg || out_ch.ready;

    // Next-state and datapath sequencing
    always_comb
    begin
        state_next     = state_reg;
        dig_cnt_next   = dig_cnt_reg;
        iter_next      = iter_reg;
        ts_next        = ts_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        yaw_next       = yaw_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        flip_next      = flip_reg;
        cmag_next      = cmag_reg;
        smag_next      = smag_reg;
        xneg_next      = xneg_reg;
        yneg_next      = yneg_reg;
        v_neg_next     = v_neg_reg;
        w_neg_next     = w_neg_reg;
        vmag_next      = vmag_reg;
        wmag_next      = wmag_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_hd_next    = out_hd_reg;

        // Take a new time step; writes must arrive only while idle, the block itself does not enforce this
        if (cfg_wr_en)
        begin
            ts_next = cfg_wr_data;
        end

        // Clear on the load cycle, then advance one digit a cycle
        if (mult_state)
        begin
            if (mult_load)
            begin
                acc_next     = '0;
                dig_cnt_next = DIG_CNT_W'(1);
            end
            else
            begin
                acc_next     = acc_step;
                mplier_next  = mplier_reg >> DIGIT_W;
                dig_cnt_next = mult_last ? '0 : dig_cnt_reg + DIG_CNT_W'(1);
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    v_neg_next = in_ch.forward_speed[15];
                    w_neg_next = in_ch.yaw_rate[15];
                    vmag_next  = vmag_in;
                    wmag_next  = wmag_in;
                    state_next = S_YAW1;
                end
            end
            S_YAW1:
            begin
                // |yaw rate| times step
                if (mult_load)
                begin
                    mcand_next  = MCAND_W'(ts_reg);
                    mplier_next = MPLIER_W'(wmag_reg);
                end
                else if (mult_last)
                begin
                    state_next = S_YAW2;
                end
            end
            S_YAW2:
            begin
                // scale radians to binary angle
                if (mult_load)
                begin
                    mcand_next  = acc_reg[MCAND_W-1:0];
                    mplier_next = INV_TWO_PI_Q32;
                end
                else if (mult_last)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                yaw_next   = w_neg_reg ? (yaw_reg - yaw_dmag) : (yaw_reg + yaw_dmag);
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                flip_next  = flip_in;
                x_next     = CORDIC_X0;
                y_next     = '0;
                z_next     = {res_ang[31], res_ang};
                iter_next  = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                if (!z_reg[CORD_W-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_z;
                end
                if (iter_reg == LAST_ITER)
                begin
                    iter_next  = '0;
                    state_next = S_VTS;
                end
                else
                begin
                    iter_next = iter_reg + ITER_W'(1);
                end
            end
            S_VTS:
            begin
                // |speed| times step; hold cos and sin as sign and magnitude
                if (mult_load)
                begin
                    mcand_next  = MCAND_W'(ts_reg);
                    mplier_next = MPLIER_W'(vmag_reg);
                    cmag_next   = x_abs[MPLIER_W-1:0];
                    smag_next   = y_abs[MPLIER_W-1:0];
                    xneg_next   = v_neg_reg ^ x_reg[CORD_W-1] ^ flip_reg;
                    yneg_next   = v_neg_reg ^ y_reg[CORD_W-1] ^ flip_reg;
                end
                else if (mult_last)
                begin
                    state_next = S_POSX;
                end
            end
            S_POSX:
            begin
                if (mult_load)
                begin
                    mcand_next  = acc_reg[MCAND_W-1:0];
                    mplier_next = cmag_reg;
                end
                else if (mult_last)
                begin
                    state_next = S_POSY;
                end
            end
            S_POSY:
            begin
                // keep the speed-step product, retire the x product
                if (mult_load)
                begin
                    mplier_next = smag_reg;
                    pos_x_next  = pos_sat;
                end
                else if (mult_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                pos_y_next = pos_sat;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_x_next     = pos_x_reg;
                    out_y_next     = pos_y_reg;
                    out_hd_next    = yaw_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dig_cnt_reg   <= '0;
            iter_reg      <= '0;
            ts_reg        <= TIME_STEP_RST;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            yaw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dig_cnt_reg   <= dig_cnt_next;
            iter_reg      <= iter_next;
            ts_reg        <= ts_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            yaw_reg       <= yaw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        flip_reg   <= flip_next;
        cmag_reg   <= cmag_next;
        smag_reg   <= smag_next;
        xneg_reg   <= xneg_next;
        yneg_reg   <= yneg_next;
        v_neg_reg  <= v_neg_next;
        w_neg_reg  <= w_neg_next;
        vmag_reg   <= vmag_next;
        wmag_reg   <= wmag_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_hd_reg <= out_hd_next;
    end

`ifndef SYNTHESIS
    // A transfer in starts the heading product
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg == S_YAW1))
        else $error("tick transfer did not start the heading product");

    // Heading moves only in its update cycle
    a_yaw_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_HEAD) |=> $stable(yaw_reg))
        else $error("heading changed outside its update cycle");

    // A taken result with no new pose pending drops valid
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && state_reg != S_OUT) |=> !out_ch.valid)
        else $error("output stayed valid after its transfer");

    // The digit counter runs only inside a product
    a_dig_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_cnt_reg != '0) |-> ((state_reg == S_YAW1) || (state_reg == S_YAW2) ||
                                 (state_reg == S_VTS) || (state_reg == S_POSX) ||
                                 (state_reg == S_POSY)))
        else $error("digit counter active outside a product");
`endif

endmodule
